// File: src/ofmc_pkg.sv
`default_nettype none

package ofmc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_GAIN_STATE      = 3'd0;
    localparam t_reg_idx REG_GAIN_COMMAND    = 3'd1;
    localparam t_reg_idx REG_GAIN_CORRECTION = 3'd2;
    localparam t_reg_idx REG_FAULT_THRESHOLD = 3'd3;
    localparam t_reg_idx REG_VEHICLE_POS     = 3'd4;

    localparam logic [15:0] RST_GAIN_STATE      = 16'd22338;
    localparam logic [15:0] RST_GAIN_COMMAND    = 16'd10430;
    localparam logic [15:0] RST_GAIN_CORRECTION = 16'd9231;
    localparam logic [14:0] RST_FAULT_THRESHOLD = 15'd256;
    localparam logic [7:0]  RST_VEHICLE_POS     = 8'd0;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_MESSAGE = 1'b1;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_NORMAL   = 2'd0;
    localparam t_mode MODE_DEGRADED = 2'd1;
    localparam t_mode MODE_SEVERE   = 2'd2;

    typedef struct packed {
        logic [15:0] gain_state;
        logic [15:0] gain_command;
        logic [15:0] gain_correction;
        logic [14:0] fault_threshold;
        logic [7:0]  vehicle_position;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/observer_fault_mode_coordinator.sv
// velocity observer with latched sensor fault and degradation mode select
// input channel: i_in_valid / o_in_stall carries one word, either a periodic
// tick (measured and commanded velocity, distance and link fault flags) or a
// coordinator message (coordinator mode), chosen by i_opcode
// output channel: o_out_valid / i_out_stall returns one word per input word:
// estimate, latched sensor fault and local mode after that word
// configuration: apb port, gains at 0x0/0x4/0x8, threshold at 0xc,
// vehicle position at 0x10; pready is always high
// an accepted word sits in an input register, then the observer and mode
// logic update the state registers, which drive the output directly
// throughput: one word per cycle while the receiver does not stall; the estimate
// feedback through the state registers is one combinational pass
// stall: when the receiver stalls, the output holds and o_in_stall rises as soon
// as the input register holds a word
// reset: synchronous active low; estimate, fault, modes cleared, registers
// return to their defaults, both channels empty
`default_nettype none

module observer_fault_mode_coordinator
    import ofmc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_opcode,
    input  wire logic signed [15:0]       i_measured_velocity,
    input  wire logic signed [15:0]       i_commanded_velocity,
    input  wire logic                     i_distance_fault,
    input  wire logic                     i_link_fault,
    input  wire logic        [1:0]        i_coordinator_mode,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed      [15:0]       o_estimate,
    output logic                          o_sensor_fault,
    output logic             [1:0]        o_local_mode,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic        [ADDR_W-1:0] paddr,
    input  wire logic        [DATA_W-1:0] pwdata,
    output logic             [DATA_W-1:0] prdata,
    output logic                          pready
);

    t_cfg cfg;

    logic               r_in_valid;
    logic               r_in_opcode;
    logic signed [15:0] r_in_meas;
    logic signed [15:0] r_in_cmd;
    logic               r_in_beta;
    logic               r_in_gamma;
    t_mode              r_in_crc;

    logic               r_out_valid;
    logic signed [15:0] r_est;
    logic               r_fault;
    t_mode              r_mode;
    t_mode              r_crc;

    logic signed [15:0] n_est;
    logic               n_fault;
    t_mode              n_mode;
    t_mode              n_crc;

    logic               adv;
    logic               take;
    logic signed [15:0] obs_est;
    logic               obs_hit;
    logic               tick_fault;
    t_mode              tick_mode;

    ofmc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ofmc_observer u_observer (
        .i_cfg       (cfg),
        .i_est       (r_est),
        .i_meas      (r_in_meas),
        .i_cmd       (r_in_cmd),
        .o_est       (obs_est),
        .o_fault_hit (obs_hit)
    );

    assign tick_fault = r_fault || obs_hit;

    ofmc_mode u_mode (
        .i_leader (cfg.vehicle_position == 8'd0),
        .i_alpha  (tick_fault),
        .i_beta   (r_in_beta),
        .i_gamma  (r_in_gamma),
        .i_crc    (r_crc),
        .i_cur    (r_mode),
        .o_mode   (tick_mode)
    );

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        n_est   = r_est;
        n_fault = r_fault;
        n_mode  = r_mode;
        n_crc   = r_crc;
        if (r_in_opcode == OP_TICK) begin
            n_est   = obs_est;
            n_fault = tick_fault;
            n_mode  = tick_mode;
        end else begin
            n_crc = r_in_crc;
            if (r_in_crc >= r_mode) begin
                n_mode = r_in_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_opcode <= i_opcode;
            r_in_meas   <= i_measured_velocity;
            r_in_cmd    <= i_commanded_velocity;
            r_in_beta   <= i_distance_fault;
            r_in_gamma  <= i_link_fault;
            r_in_crc    <= i_coordinator_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_est       <= '0;
            r_fault     <= 1'b0;
            r_mode      <= MODE_NORMAL;
            r_crc       <= MODE_NORMAL;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_est   <= n_est;
                r_fault <= n_fault;
                r_mode  <= n_mode;
                r_crc   <= n_crc;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_estimate     = r_est;
    assign o_sensor_fault = r_fault;
    assign o_local_mode   = r_mode;

endmodule

`default_nettype wire

// File: src/ofmc_regs.sv
`default_nettype none

module ofmc_regs
    import ofmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_GAIN_STATE:      n_cfg.gain_state       = pwdata[15:0];
                REG_GAIN_COMMAND:    n_cfg.gain_command     = pwdata[15:0];
                REG_GAIN_CORRECTION: n_cfg.gain_correction  = pwdata[15:0];
                REG_FAULT_THRESHOLD: n_cfg.fault_threshold  = pwdata[14:0];
                REG_VEHICLE_POS:     n_cfg.vehicle_position = pwdata[7:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_state       <= RST_GAIN_STATE;
            r_cfg.gain_command     <= RST_GAIN_COMMAND;
            r_cfg.gain_correction  <= RST_GAIN_CORRECTION;
            r_cfg.fault_threshold  <= RST_FAULT_THRESHOLD;
            r_cfg.vehicle_position <= RST_VEHICLE_POS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_GAIN_STATE:      prdata = {16'd0, r_cfg.gain_state};
            REG_GAIN_COMMAND:    prdata = {16'd0, r_cfg.gain_command};
            REG_GAIN_CORRECTION: prdata = {16'd0, r_cfg.gain_correction};
            REG_FAULT_THRESHOLD: prdata = {17'd0, r_cfg.fault_threshold};
            REG_VEHICLE_POS:     prdata = {24'd0, r_cfg.vehicle_position};
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/ofmc_observer.sv
`default_nettype none

module ofmc_observer
    import ofmc_pkg::*;
(
    input  wire t_cfg               i_cfg,
    input  wire logic signed [15:0] i_est,
    input  wire logic signed [15:0] i_meas,
    input  wire logic signed [15:0] i_cmd,
    output logic signed      [15:0] o_est,
    output logic                    o_fault_hit
);

    localparam logic signed [35:0] ROUND_HALF = 36'sd16384;

    logic signed [16:0] gs_s;
    logic signed [16:0] gm_s;
    logic signed [16:0] gc_s;
    logic signed [16:0] diff;
    logic signed [32:0] p_state;
    logic signed [32:0] p_cmd;
    logic signed [33:0] p_corr;
    logic signed [35:0] acc;
    logic signed [20:0] q;
    logic signed [16:0] resid;
    logic        [16:0] mag;

    assign gs_s = {1'b0, i_cfg.gain_state};
    assign gm_s = {1'b0, i_cfg.gain_command};
    assign gc_s = {1'b0, i_cfg.gain_correction};
    assign diff = {i_meas[15], i_meas} - {i_est[15], i_est};

    assign p_state = gs_s * 33'(i_est);
    assign p_cmd   = gm_s * 33'(i_cmd);
    assign p_corr  = gc_s * diff;

    assign acc = 36'(p_state) + 36'(p_cmd) + 36'(p_corr) + ROUND_HALF;
    assign q   = acc[35:15];

    always_comb begin
        if (q > 21'sd32767) begin
            o_est = 16'sh7fff;
        end else if (q < -21'sd32768) begin
            o_est = 16'sh8000;
        end else begin
            o_est = q[15:0];
        end
    end

    assign resid       = {i_meas[15], i_meas} - {o_est[15], o_est};
    assign mag         = resid[16] ? 17'(-resid) : 17'(resid);
    assign o_fault_hit = mag > {2'b00, i_cfg.fault_threshold};

endmodule

`default_nettype wire

// File: src/ofmc_mode.sv
`default_nettype none

module ofmc_mode
    import ofmc_pkg::*;
(
    input  wire logic        i_leader,
    input  wire logic        i_alpha,
    input  wire logic        i_beta,
    input  wire logic        i_gamma,
    input  wire t_mode       i_crc,
    input  wire t_mode       i_cur,
    output t_mode            o_mode
);

    logic low;
    logic crc_normal;

    assign low        = (i_crc == MODE_NORMAL) || (i_crc == MODE_DEGRADED);
    assign crc_normal = (i_crc == MODE_NORMAL);

    always_comb begin
        o_mode = i_cur;
        if (i_leader) begin
            if (i_beta) begin
                o_mode = MODE_SEVERE;
            end else if ((i_alpha || i_gamma) && low) begin
                o_mode = MODE_DEGRADED;
            end else if (crc_normal) begin
                o_mode = MODE_NORMAL;
            end
        end else begin
            if (i_beta && i_gamma) begin
                o_mode = MODE_SEVERE;
            end else if ((i_alpha || i_beta || i_gamma) && low) begin
                o_mode = MODE_DEGRADED;
            end else if (crc_normal) begin
                o_mode = MODE_NORMAL;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/ofmc_checker.sv
`default_nettype none

module ofmc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_estimate,
    input wire logic        o_sensor_fault,
    input wire logic [1:0]  o_local_mode
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_estimate)
            && $stable(o_sensor_fault) && $stable(o_local_mode))
        else $error("stalled output word changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output is free");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sensor_fault |=> o_sensor_fault)
        else $error("sensor fault cleared without reset");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("output word without an accepted input word");

endmodule

bind observer_fault_mode_coordinator ofmc_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_estimate     (o_estimate),
    .o_sensor_fault (o_sensor_fault),
    .o_local_mode   (o_local_mode)
);

`default_nettype wire

// File: verif/observer_fault_mode_coordinator_test.sv
`timescale 1ns / 1ps

module observer_fault_mode_coordinator_test;
    import ofmc_pkg::*;

    localparam t_mode    MODE_HELD     = 2'd3;
    localparam t_reg_idx REG_SPARE_LO  = 3'd5;
    localparam t_reg_idx REG_SPARE_HI  = 3'd7;
    localparam int       HOLD_CYCLES   = 80;
    localparam int       DRAIN_CYCLES  = 4;
    localparam int       SEGMENTS      = 9;
    localparam int       SEG_WORDS     = 215;

    typedef struct packed {
        logic signed [15:0] estimate;
        logic               sensor_fault;
        t_mode              local_mode;
    } t_status;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               i_opcode = 1'b0;
    logic signed [15:0] i_measured_velocity = '0;
    logic signed [15:0] i_commanded_velocity = '0;
    logic               i_distance_fault = 1'b0;
    logic               i_link_fault = 1'b0;
    logic [1:0]         i_coordinator_mode = '0;
    logic               i_out_stall = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [15:0] o_estimate;
    logic               o_sensor_fault;
    logic [1:0]         o_local_mode;

    t_cfg cfg_shadow = '{RST_GAIN_STATE, RST_GAIN_COMMAND, RST_GAIN_CORRECTION,
                         RST_FAULT_THRESHOLD, RST_VEHICLE_POS};
    logic signed [15:0] est_shadow = '0;
    logic               fault_shadow = 1'b0;
    t_mode              mode_shadow = MODE_NORMAL;
    t_mode              coord_shadow = MODE_NORMAL;

    t_status pending_status[$];
    t_status oldest;
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;

    observer_fault_mode_coordinator u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_opcode             (i_opcode),
        .i_measured_velocity  (i_measured_velocity),
        .i_commanded_velocity (i_commanded_velocity),
        .i_distance_fault     (i_distance_fault),
        .i_link_fault         (i_link_fault),
        .i_coordinator_mode   (i_coordinator_mode),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_estimate           (o_estimate),
        .o_sensor_fault       (o_sensor_fault),
        .o_local_mode         (o_local_mode),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always #1 i_clk = ~i_clk;

    // observer update and mode selection for one accepted word
    function automatic void observe_word(input logic op, input logic signed [15:0] meas,
                                         input logic signed [15:0] cmd, input logic dist_flt,
                                         input logic link, input t_mode coord);
        longint  est;
        longint  acc;
        longint  q;
        longint  resid;
        logic    low;
        t_status st;
        if (op == OP_TICK) begin
            est = est_shadow;
            acc = longint'(cfg_shadow.gain_state) * est
                + longint'(cfg_shadow.gain_command) * longint'(cmd)
                + longint'(cfg_shadow.gain_correction) * (longint'(meas) - est);
            q = (acc + 64'sd16384) >>> 15;
            if (q > 64'sd32767) begin
                q = 64'sd32767;
            end else if (q < -64'sd32768) begin
                q = -64'sd32768;
            end
            est_shadow = q[15:0];
            resid = longint'(meas) - q;
            if (resid < 0) begin
                resid = -resid;
            end
            if (resid > longint'(cfg_shadow.fault_threshold)) begin
                fault_shadow = 1'b1;
            end
            low = (coord_shadow == MODE_NORMAL) || (coord_shadow == MODE_DEGRADED);
            if (cfg_shadow.vehicle_position == 8'd0) begin
                if (dist_flt) begin
                    mode_shadow = MODE_SEVERE;
                end else if ((fault_shadow || link) && low) begin
                    mode_shadow = MODE_DEGRADED;
                end else if (coord_shadow == MODE_NORMAL) begin
                    mode_shadow = MODE_NORMAL;
                end
            end else begin
                if (dist_flt && link) begin
                    mode_shadow = MODE_SEVERE;
                end else if ((fault_shadow || dist_flt || link) && low) begin
                    mode_shadow = MODE_DEGRADED;
                end else if (coord_shadow == MODE_NORMAL) begin
                    mode_shadow = MODE_NORMAL;
                end
            end
        end else begin
            coord_shadow = coord;
            if (coord >= mode_shadow) begin
                mode_shadow = coord;
            end
        end
        st.estimate = est_shadow;
        st.sensor_fault = fault_shadow;
        st.local_mode = mode_shadow;
        pending_status.push_back(st);
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return 32'hFFFF;
            2: return $urandom;
            default: return $urandom_range(32'h8000);
        endcase
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic send_word(input logic op, input logic signed [15:0] meas,
                             input logic signed [15:0] cmd, input logic dist_flt,
                             input logic link, input t_mode coord);
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_measured_velocity <= meas;
        i_commanded_velocity <= cmd;
        i_distance_fault <= dist_flt;
        i_link_fault <= link;
        i_coordinator_mode <= coord;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        observe_word(op, meas, cmd, dist_flt, link, coord);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_tick(input logic signed [15:0] meas, input logic signed [15:0] cmd,
                             input logic dist_flt, input logic link);
        send_word(OP_TICK, meas, cmd, dist_flt, link, t_mode'($urandom_range(3)));
    endtask

    task automatic send_message(input t_mode coord);
        send_word(OP_MESSAGE, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), coord);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GAIN_STATE:      cfg_shadow.gain_state = value[15:0];
            REG_GAIN_COMMAND:    cfg_shadow.gain_command = value[15:0];
            REG_GAIN_CORRECTION: cfg_shadow.gain_correction = value[15:0];
            REG_FAULT_THRESHOLD: cfg_shadow.fault_threshold = value[14:0];
            REG_VEHICLE_POS:     cfg_shadow.vehicle_position = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_leader_rules();
        set_idle(35, 50);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b1);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_tick(16'sd0, 16'sd0, 1'b1, 1'b0);
        send_message(MODE_DEGRADED);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_message(MODE_SEVERE);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b1);
        send_message(MODE_NORMAL);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_follower_rules();
        apb_write(REG_VEHICLE_POS, 32'd1);
        send_tick(16'sd0, 16'sd0, 1'b1, 1'b0);
        send_tick(16'sd0, 16'sd0, 1'b1, 1'b1);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        wait_idle();
        apb_write(REG_VEHICLE_POS, 32'hFF);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b1);
        // coordinator mode three sticks on clean ticks
        send_message(MODE_HELD);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_message(MODE_NORMAL);
        send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
        wait_idle();
        apb_write(REG_VEHICLE_POS, 32'd0);
    endtask

    task automatic test_field_extremes();
        send_tick(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
        send_tick(-16'sh8000, -16'sh8000, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        // gains near two, estimate saturates both ways
        apb_write(REG_GAIN_STATE, 32'hFFFF);
        apb_write(REG_GAIN_COMMAND, 32'hFFFF);
        apb_write(REG_GAIN_CORRECTION, 32'hFFFF);
        apb_write(REG_FAULT_THRESHOLD, 32'd0);
        send_tick(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
        send_tick(-16'sh8000, -16'sh8000, 1'b0, 1'b0);
        wait_idle();
        apb_write(REG_GAIN_STATE, 32'd0);
        apb_write(REG_GAIN_COMMAND, 32'd0);
        apb_write(REG_GAIN_CORRECTION, 32'd0);
        apb_write(REG_FAULT_THRESHOLD, 32'hFFFF_FFFF);
        // unmapped addresses must not alias onto real registers
        apb_write(REG_SPARE_LO, 32'hFFFF);
        apb_write(REG_SPARE_HI, 32'hFFFF);
        send_tick(16'sh7FFF, -16'sh8000, 1'b0, 1'b0);
        wait_idle();
        apb_write(REG_GAIN_STATE, 32'(RST_GAIN_STATE));
        apb_write(REG_GAIN_COMMAND, 32'(RST_GAIN_COMMAND));
        apb_write(REG_GAIN_CORRECTION, 32'(RST_GAIN_CORRECTION));
        apb_write(REG_FAULT_THRESHOLD, 32'(RST_FAULT_THRESHOLD));
    endtask

    task automatic test_input_backpressure();
        set_idle(0, 0);
        hold_requests <= hold_requests + 1;
        repeat (40) send_tick(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int r;
        int m;
        int span;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                set_idle(35, 50);
            end else if (seg == 3) begin
                set_idle(50, 35);
            end else if (seg == 6) begin
                set_idle(0, 0);
            end
            wait_idle();
            apb_write(REG_GAIN_STATE, pick_gain());
            apb_write(REG_GAIN_COMMAND, pick_gain());
            apb_write(REG_GAIN_CORRECTION, pick_gain());
            apb_write(REG_FAULT_THRESHOLD,
                      ($urandom_range(2) == 0) ? $urandom : $urandom_range(1024));
            apb_write(REG_VEHICLE_POS, ($urandom_range(1) == 0) ? 32'd0 : $urandom);
            for (int n = 0; n < SEG_WORDS; n++) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    send_message(($urandom_range(99) < 15) ? MODE_HELD
                                                            : t_mode'($urandom_range(2)));
                end else if (r < 60) begin
                    // measurement close to the estimate, around the threshold
                    span = int'(cfg_shadow.fault_threshold) + 8;
                    m = int'(est_shadow) + int'($urandom_range(2 * span)) - span;
                    if (m > 32767) begin
                        m = 32767;
                    end else if (m < -32768) begin
                        m = -32768;
                    end
                    send_tick(16'(m), 16'(m), 1'($urandom), 1'($urandom));
                end else begin
                    send_tick(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
                end
            end
        end
        wait_idle();
    endtask

    // output side: random stall, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_status.size() == 0) begin
                $display("%0t: word with no prediction, estimate %0d fault %0b mode %0d",
                         $time, o_estimate, o_sensor_fault, o_local_mode);
                errors++;
            end else begin
                oldest = pending_status.pop_front();
                if (o_estimate !== oldest.estimate) begin
                    $display("%0t: estimate expected %0d actual %0d",
                             $time, oldest.estimate, o_estimate);
                    errors++;
                end
                if (o_sensor_fault !== oldest.sensor_fault) begin
                    $display("%0t: sensor fault expected %0b actual %0b",
                             $time, oldest.sensor_fault, o_sensor_fault);
                    errors++;
                end
                if (o_local_mode !== oldest.local_mode) begin
                    $display("%0t: local mode expected %0d actual %0d",
                             $time, oldest.local_mode, o_local_mode);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_leader_rules();
        test_follower_rules();
        test_field_extremes();
        test_config_extremes();
        test_input_backpressure();
        test_random_traffic();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout, %0d words still pending", pending_status.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
src/ofmc_pkg.sv
src/ofmc_regs.sv
src/ofmc_observer.sv
src/ofmc_mode.sv
src/observer_fault_mode_coordinator.sv
src/ofmc_checker.sv
verif/observer_fault_mode_coordinator_test.sv
